// ----- rtl/tccs_pkg.sv -----
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants for the terminal control char sanitizer
// Byte codes, allow-mask bit positions, controller/datapath command and status.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Byte codes
  localparam logic [7:0] NUL_BYTE     = 8'h00;
  localparam logic [7:0] TAB_BYTE     = 8'h09;
  localparam logic [7:0] LF_BYTE      = 8'h0A;
  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] DIGIT_LO     = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_HI     = 8'h39;  // '9'
  localparam logic [7:0] SEMI_BYTE    = 8'h3B;  // ';'
  localparam logic [7:0] QMARK_BYTE   = 8'h3F;  // '?'
  localparam logic [7:0] CARET_OFFSET = 8'h40;
  localparam logic [7:0] CUR_LO       = 8'h41;  // 'A'
  localparam logic [7:0] CUR_HI       = 8'h48;  // 'H'
  localparam logic [7:0] CUR_F        = 8'h66;  // 'f'
  localparam logic [7:0] ERASE_J      = 8'h4A;  // 'J'
  localparam logic [7:0] ERASE_K      = 8'h4B;  // 'K'
  localparam logic [7:0] ERASE_M      = 8'h4D;  // 'M'
  localparam logic [7:0] ERASE_P      = 8'h50;  // 'P'
  localparam logic [7:0] ERASE_X      = 8'h58;  // 'X'
  localparam logic [7:0] LBRACK_BYTE  = 8'h5B;  // '['
  localparam logic [7:0] CARET_BYTE   = 8'h5E;  // '^'
  localparam logic [7:0] COLOR_FINAL  = 8'h6D;  // 'm'
  localparam logic [7:0] DEL_BYTE     = 8'h7F;

  // allow_mask bits
  localparam int unsigned MASK_COLOR  = 0;
  localparam int unsigned MASK_CURSOR = 1;
  localparam int unsigned MASK_ERASE  = 2;
  localparam int unsigned MASK_PASS   = 3;
  localparam logic [3:0]  ALLOW_RESET = 4'h8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE_HI,
    S_PRE_LO,
    S_RUN,
    S_BYTE_HI,
    S_BYTE_LO
  } state_e;

  // What comes ahead of the held run: nothing, the sequence as-is, or "^["
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_PASS,
    PRE_FAIL
  } pre_e;

  // What the current byte itself turns into
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RAW,
    ACT_CARET,
    ACT_HOLD_ESC
  } act_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_ONE,
    CNT_CLEAR
  } cnt_op_e;

  typedef enum logic [1:0] {
    IDX_KEEP,
    IDX_ONE,
    IDX_INC
  } idx_op_e;

  typedef enum logic [2:0] {
    SEL_ESC,
    SEL_CARET,
    SEL_LBRACK,
    SEL_HELD,
    SEL_RAW,
    SEL_CTRL
  } sel_e;

  typedef struct packed {
    logic    accept;
    logic    ovf;
    logic    drop_nxt;
    logic    wr;
    cnt_op_e cnt_op;
    idx_op_e idx_op;
    logic    emit;
    sel_e    sel;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic seg_last;
    logic dropping;
    logic pass_all;
    logic esc_ok;
    logic is_nul;
    logic is_print;
    logic is_esc;
    logic is_lbrack;
    logic is_digit;
    logic is_final;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic run_empty;
    logic run_end;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/tccs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccs_ctrl: sequencer of the terminal control char sanitizer
// Decides what one input byte produces and steps through the output bytes.
// ----------------------------------------------------------------------------
module tccs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tccs_pkg::sts_t sts_i,
  output tccs_pkg::cmd_t cmd_o
);
  import tccs_pkg::*;

  state_e state_q, state_d;
  pre_e   pre_q, pre_d;
  act_e   act_q, act_d;
  logic   tail_q, tail_d;

  act_e   fresh_act;
  pre_e   pl_pre;
  act_e   pl_act;
  logic   pl_store;
  logic   pl_ovf;
  logic   pl_tail;
  logic   act_out;
  logic   more;
  logic   fin;
  cnt_op_e fin_cnt;

  // byte handled as if nothing were held
  always_comb begin
    if (sts_i.is_nul) begin
      fresh_act = ACT_NONE;
    end else if (sts_i.is_print) begin
      fresh_act = ACT_RAW;
    end else if (sts_i.is_esc && sts_i.esc_ok) begin
      fresh_act = ACT_HOLD_ESC;
    end else begin
      fresh_act = ACT_CARET;
    end
  end

  // plan for the byte on the input
  always_comb begin
    pl_pre   = PRE_NONE;
    pl_act   = ACT_NONE;
    pl_store = 1'b0;
    pl_ovf   = 1'b0;
    if (sts_i.dropping) begin
      pl_act = ACT_NONE;
    end else if (sts_i.pass_all) begin
      pl_pre = sts_i.cnt_zero ? PRE_NONE : PRE_PASS;
      pl_act = ACT_RAW;
    end else if (sts_i.cnt_zero) begin
      pl_act = fresh_act;
    end else if (sts_i.cnt_one) begin
      if (sts_i.is_lbrack) begin
        pl_store = 1'b1;
      end else begin
        pl_pre = PRE_FAIL;
        pl_act = fresh_act;
      end
    end else if (sts_i.is_final) begin
      pl_pre = PRE_PASS;
      pl_act = ACT_RAW;
    end else if (sts_i.is_digit) begin
      if (!sts_i.cnt_full) begin
        pl_store = 1'b1;
      end else begin
        pl_ovf = 1'b1;
        pl_pre = PRE_FAIL;
        pl_act = fresh_act;
      end
    end else begin
      pl_pre = PRE_FAIL;
      pl_act = fresh_act;
    end
    pl_tail = sts_i.seg_last && !sts_i.dropping && (pl_store || pl_act == ACT_HOLD_ESC);
  end

  assign act_out    = (act_q == ACT_RAW) || (act_q == ACT_CARET);
  assign more       = act_out || tail_q;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    if (act_q == ACT_HOLD_ESC) begin
      fin_cnt = CNT_ONE;
    end else if (pre_q != PRE_NONE) begin
      fin_cnt = CNT_CLEAR;
    end else begin
      fin_cnt = CNT_KEEP;
    end
  end

  always_comb begin
    state_d = state_q;
    pre_d   = pre_q;
    act_d   = act_q;
    tail_d  = tail_q;
    fin     = 1'b0;
    cmd_o   = '{accept: 1'b0, ovf: 1'b0, drop_nxt: 1'b0, wr: 1'b0, cnt_op: CNT_KEEP,
                idx_op: IDX_KEEP, emit: 1'b0, sel: SEL_RAW, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept   = 1'b1;
          cmd_o.ovf      = pl_ovf;
          cmd_o.drop_nxt = (sts_i.dropping || (!sts_i.pass_all && sts_i.is_nul)) &&
                           !sts_i.seg_last;
          cmd_o.idx_op   = IDX_ONE;
          pre_d          = pl_pre;
          act_d          = pl_act;
          tail_d         = pl_tail;
          if (pl_store) begin
            cmd_o.wr     = 1'b1;
            cmd_o.cnt_op = CNT_INC;
          end
          if (pl_pre != PRE_NONE) begin
            state_d = S_PRE_HI;
          end else if (pl_act == ACT_RAW || pl_act == ACT_CARET) begin
            state_d = S_BYTE_HI;
          end else begin
            // nothing to show for this byte itself
            if (pl_act == ACT_HOLD_ESC) begin
              cmd_o.cnt_op = CNT_ONE;
            end
            if (pl_tail) begin
              state_d = S_PRE_HI;
              pre_d   = PRE_FAIL;
              act_d   = ACT_NONE;
              tail_d  = 1'b0;
            end
          end
        end
      end
      S_PRE_HI: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (pre_q == PRE_PASS) begin
            cmd_o.sel  = SEL_ESC;
            cmd_o.last = sts_i.run_empty && !more;
            if (!sts_i.run_empty) begin
              state_d = S_RUN;
            end else if (act_out) begin
              state_d = S_BYTE_HI;
            end else begin
              fin = 1'b1;
            end
          end else begin
            cmd_o.sel = SEL_CARET;
            state_d   = S_PRE_LO;
          end
        end
      end
      S_PRE_LO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_LBRACK;
          cmd_o.last = sts_i.run_empty && !more;
          if (!sts_i.run_empty) begin
            state_d = S_RUN;
          end else if (act_out) begin
            state_d = S_BYTE_HI;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = SEL_HELD;
          cmd_o.idx_op = IDX_INC;
          cmd_o.last   = sts_i.run_end && !more;
          if (sts_i.run_end) begin
            if (act_out) begin
              state_d = S_BYTE_HI;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      S_BYTE_HI: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (act_q == ACT_RAW) begin
            cmd_o.sel  = SEL_RAW;
            cmd_o.last = !tail_q;
            fin        = 1'b1;
          end else begin
            cmd_o.sel = SEL_CARET;
            state_d   = S_BYTE_LO;
          end
        end
      end
      S_BYTE_LO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_CTRL;
          cmd_o.last = !tail_q;
          fin        = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of the main part: settle the count, then flush a leftover sequence
    if (fin) begin
      cmd_o.cnt_op = fin_cnt;
      if (tail_q) begin
        state_d      = S_PRE_HI;
        pre_d        = PRE_FAIL;
        act_d        = ACT_NONE;
        tail_d       = 1'b0;
        cmd_o.idx_op = IDX_ONE;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pre_q   <= PRE_NONE;
      act_q   <= ACT_NONE;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pre_q   <= pre_d;
      act_q   <= act_d;
      tail_q  <= tail_d;
    end
  end

endmodule

// ----- rtl/tccs_dp.sv -----
// ----------------------------------------------------------------------------
// tccs_dp: datapath of the terminal control char sanitizer
// Mask register, holding memory, counters, byte classifier and output register.
// ----------------------------------------------------------------------------
module tccs_dp #(
  parameter int unsigned SEQ_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     in_byte_i,
  input  logic           seg_last_i,
  input  logic           cfg_valid_i,
  input  logic [3:0]     allow_mask_i,
  input  logic           out_ready_i,
  input  tccs_pkg::cmd_t cmd_i,
  output tccs_pkg::sts_t sts_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           overflowed_o
);
  import tccs_pkg::*;

  localparam int unsigned CW = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned AW = $clog2(SEQ_DEPTH);

  logic [3:0]    mask_q;
  logic          dropping_q;
  logic          ovf_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    byte_q;
  logic [7:0]    held_q [SEQ_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic          out_valid_q;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q;
  logic          out_ovf_q;
  logic          is_cursor, is_erase;

  // byte classes of the input
  assign is_cursor = (in_byte_i inside {[CUR_LO:CUR_HI], CUR_F});
  assign is_erase  = (in_byte_i inside {ERASE_J, ERASE_K, ERASE_M, ERASE_P, ERASE_X});

  assign sts_o.seg_last  = seg_last_i;
  assign sts_o.dropping  = dropping_q;
  assign sts_o.pass_all  = mask_q[MASK_PASS];
  assign sts_o.esc_ok    = mask_q[MASK_COLOR] | mask_q[MASK_CURSOR] | mask_q[MASK_ERASE];
  assign sts_o.is_nul    = (in_byte_i == NUL_BYTE);
  assign sts_o.is_print  = ((in_byte_i >= SPACE_BYTE) && (in_byte_i != DEL_BYTE)) ||
                           (in_byte_i == TAB_BYTE) || (in_byte_i == LF_BYTE);
  assign sts_o.is_esc    = (in_byte_i == ESC_BYTE);
  assign sts_o.is_lbrack = (in_byte_i == LBRACK_BYTE);
  assign sts_o.is_digit  = (in_byte_i inside {[DIGIT_LO:DIGIT_HI], SEMI_BYTE});
  assign sts_o.is_final  = (mask_q[MASK_COLOR] && (in_byte_i == COLOR_FINAL)) ||
                           (mask_q[MASK_CURSOR] && is_cursor) ||
                           (mask_q[MASK_ERASE] && is_erase);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.cnt_one   = (cnt_q == CW'(1));
  assign sts_o.cnt_full  = (cnt_q == CW'(SEQ_DEPTH));
  assign sts_o.run_empty = (cnt_q <= CW'(1));
  assign sts_o.run_end   = ((idx_q + CW'(1)) == cnt_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_KEEP:  cnt_d = cnt_q;
      CNT_INC:   cnt_d = cnt_q + CW'(1);
      CNT_ONE:   cnt_d = CW'(1);
      CNT_CLEAR: cnt_d = '0;
      default:   cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_KEEP: idx_d = idx_q;
      IDX_ONE:  idx_d = CW'(1);
      IDX_INC:  idx_d = idx_q + CW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  // read address follows the next index so rd_q lines up with idx_q
  assign rd_addr = (idx_d < CW'(SEQ_DEPTH)) ? idx_d[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      held_q[cnt_q[AW-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= held_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= ALLOW_RESET;
      dropping_q <= 1'b0;
      ovf_q      <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= allow_mask_i;
      end
      if (cmd_i.accept) begin
        dropping_q <= cmd_i.drop_nxt;
        ovf_q      <= cmd_i.ovf;
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_ESC:    out_byte_d = ESC_BYTE;
      SEL_CARET:  out_byte_d = CARET_BYTE;
      SEL_LBRACK: out_byte_d = LBRACK_BYTE;
      SEL_HELD:   out_byte_d = rd_q;
      SEL_RAW:    out_byte_d = byte_q;
      SEL_CTRL:   out_byte_d = (byte_q == DEL_BYTE) ? QMARK_BYTE : byte_q + CARET_OFFSET;
      default:    out_byte_d = byte_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= out_byte_d;
      out_last_q <= cmd_i.last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = out_last_q;
  assign overflowed_o = out_ovf_q;

endmodule

// ----- rtl/terminal_control_char_sanitizer.sv -----
// ----------------------------------------------------------------------------
// terminal_control_char_sanitizer: byte filter for terminal output
// Passes printable text, shows control bytes as caret pairs, and lets through
// only those CSI sequences whose final byte the allow mask permits.
// ----------------------------------------------------------------------------
// Takes one byte per request on the in channel and returns zero or more bytes
// on the out channel; run_last_o marks the last byte caused by an input byte
// and overflowed_o is set on every byte of a request that flushed a sequence
// because the holding memory (SEQ_DEPTH bytes) was full. A byte that yields
// no output (held back, dropped after a NUL) leaves the sequencer idle. For a
// byte with output, in_ready_o stays low until its last byte is emitted:
// the sequencer drives the output register one byte per cycle while out_free
// holds, held bytes coming out of the holding memory at one read per cycle.
// The next byte is accepted while the previous result still sits in the
// output register. allow_mask_i (bit0 color, bit1 cursor, bit2 erase, bit3
// pass everything) resets to pass-everything and must only be written while
// no request is in progress.
// ----------------------------------------------------------------------------
module terminal_control_char_sanitizer #(
  parameter int unsigned SEQ_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       seg_last_i,
  // sanitized bytes
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       overflowed_o,
  // allow mask write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] allow_mask_i
);
  import tccs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the mask register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dp #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .seg_last_i   (seg_last_i),
    .cfg_valid_i  (cfg_valid_i),
    .allow_mask_i (allow_mask_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .overflowed_o (overflowed_o)
  );

endmodule
